// File: sv/mlfp_pkg.sv
// ----------------------------------------------------------------------------
// mlfp_pkg
// Shared types and constants of the motor link frame parser.
// ----------------------------------------------------------------------------
package mlfp_pkg;

	localparam int MAX_ENTRIES     = 16;
	localparam int ALL_STATE_COUNT = 9;
	localparam int WORD_BYTES      = 4;
	localparam int LOOKBACK_DEPTH  = 3;
	localparam int CFG_IDX_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GENERAL_HDR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_HDR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_CODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_ID  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_STATE_ID = 3'd5;

	localparam logic [7:0] GENERAL_HDR_RST  = 8'd175;
	localparam logic [7:0] SPEED_HDR_RST    = 8'd179;
	localparam logic [7:0] READ_CODE_RST    = 8'd0;
	localparam logic [7:0] WRITE_CODE_RST   = 8'd1;
	localparam logic [7:0] BATTERY_ID_RST   = 8'd1;
	localparam logic [7:0] ALL_STATE_ID_RST = 8'd6;

	typedef enum logic [1:0] {
		KIND_SPEED,
		KIND_BATTERY,
		KIND_ALL_STATE,
		KIND_GENERIC
	} frame_kind_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SPEED,
		PH_DEVICE,
		PH_RW,
		PH_COUNT,
		PH_IDS,
		PH_WORDS
	} phase_t;

	typedef enum logic [2:0] {
		CS_FEED,
		CS_RESCAN,
		CS_DIRECT,
		CS_READ,
		CS_LOAD
	} ctl_state_t;

	typedef struct packed {
		logic       feed;
		logic       use_queue;
		logic [1:0] queue_sel;
		logic       rd_issue;
		logic       load_direct;
		logic       load_entry;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic fin_direct;
		logic fin_general;
		logic last_entry;
		logic out_free;
	} dp_stat_t;

endpackage

// File: sv/mlfp_ifs.sv
// ----------------------------------------------------------------------------
// mlfp_ifs
// Channel interfaces: received bytes, parsed results, register writes.
// ----------------------------------------------------------------------------
interface mlfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlfp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_kind;
	logic [7:0]  device_id;
	logic        is_write;
	logic [4:0]  entry_count;
	logic [3:0]  entry_index;
	logic [7:0]  entry_id;
	logic [31:0] entry_word;
	logic        last_entry;

	modport source (
		output valid, output frame_kind, output device_id, output is_write,
		output entry_count, output entry_index, output entry_id, output entry_word,
		output last_entry, input ready
	);
	modport sink (
		input valid, input frame_kind, input device_id, input is_write,
		input entry_count, input entry_index, input entry_id, input entry_word,
		input last_entry, output ready
	);
endinterface

interface mlfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/mlfp_ram.sv
// ----------------------------------------------------------------------------
// mlfp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/mlfp_ctl.sv
// ----------------------------------------------------------------------------
// mlfp_ctl
// Controller: byte intake, lookback rescan, result emission sequencing.
// ----------------------------------------------------------------------------
module mlfp_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	output mlfp_pkg::dp_cmd_t cmd,
	input  mlfp_pkg::dp_stat_t stat
);
	import mlfp_pkg::*;

	localparam logic [1:0] RS_LAST = 2'(LOOKBACK_DEPTH - 1);

	ctl_state_t state_q, state_d;
	logic [1:0] rs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_FEED;
			rs_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_RESCAN && rs_q != RS_LAST) begin
				rs_q <= rs_q + 2'd1;
			end else begin
				rs_q <= 2'd0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_FEED: begin
				if (rx_valid) begin
					if (stat.bad) begin
						state_d = CS_RESCAN;
					end else if (stat.fin_direct) begin
						state_d = CS_DIRECT;
					end else if (stat.fin_general) begin
						state_d = CS_READ;
					end
				end
			end
			CS_RESCAN: begin
				if (rs_q == RS_LAST) begin
					state_d = CS_FEED;
				end
			end
			CS_DIRECT: begin
				if (stat.out_free) begin
					state_d = CS_FEED;
				end
			end
			CS_READ: begin
				state_d = CS_LOAD;
			end
			CS_LOAD: begin
				if (stat.out_free) begin
					state_d = stat.last_entry ? CS_FEED : CS_READ;
				end
			end
			default: begin
				state_d = CS_FEED;
			end
		endcase
	end

	always_comb begin
		rx_ready        = 1'b0;
		cmd             = '0;
		cmd.queue_sel   = rs_q;
		case (state_q)
			CS_FEED: begin
				rx_ready = 1'b1;
				cmd.feed = rx_valid;
			end
			CS_RESCAN: begin
				cmd.feed      = 1'b1;
				cmd.use_queue = 1'b1;
			end
			CS_DIRECT: begin
				cmd.load_direct = stat.out_free;
			end
			CS_READ: begin
				cmd.rd_issue = 1'b1;
			end
			CS_LOAD: begin
				cmd.load_entry = stat.out_free;
			end
			default: begin
				rx_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: sv/mlfp_dp.sv
// ----------------------------------------------------------------------------
// mlfp_dp
// Datapath: parse phase, frame fields, id and word stores, result register.
// ----------------------------------------------------------------------------
module mlfp_dp #(
	parameter int MAX_ENTRIES = mlfp_pkg::MAX_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mlfp_pkg::dp_cmd_t          cmd,
	output mlfp_pkg::dp_stat_t         stat,
	input  logic [7:0]                 rx_byte,
	input  logic                       cfg_we,
	input  logic [mlfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                 cfg_data,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [1:0]                 frame_kind,
	output logic [7:0]                 device_id,
	output logic                       is_write,
	output logic [4:0]                 entry_count,
	output logic [3:0]                 entry_index,
	output logic [7:0]                 entry_id,
	output logic [31:0]                entry_word,
	output logic                       last_entry
);
	import mlfp_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [1:0] LAST_SUB = 2'(WORD_BYTES - 1);

	logic [7:0] general_hdr_q, speed_hdr_q, read_code_q, write_code_q;
	logic [7:0] battery_id_q, all_state_id_q;

	phase_t      phase_q;
	logic [1:0]  sub_q;
	logic [IDX_W-1:0] idx_q, emit_idx_q;
	logic [7:0]  dev_q, rw_q, first_id_q;
	logic        is_write_q, match_q, direct_speed_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0] asm_q;
	logic [7:0]  queue_q [LOOKBACK_DEPTH];

	logic        out_valid_q, out_last_q, out_write_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_dev_q, out_id_q;
	logic [4:0]  out_count_q;
	logic [3:0]  out_index_q;
	logic [31:0] out_word_q;

	logic [7:0]  byte_in;
	logic [31:0] asm_new;
	logic        idx_last, frame_ok, id_we, word_we;
	logic [7:0]  id_rd;
	logic [31:0] word_rd;
	frame_kind_t entry_kind;

	assign byte_in  = cmd.use_queue ? queue_q[cmd.queue_sel] : rx_byte;
	assign asm_new  = asm_q | (32'(byte_in) << {sub_q, 3'b000});
	assign idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign frame_ok = (rw_q == read_code_q || rw_q == write_code_q)
		&& (byte_in <= 8'(MAX_ENTRIES));

	assign id_we   = cmd.feed && phase_q == PH_IDS;
	assign word_we = cmd.feed && phase_q == PH_WORDS && sub_q == LAST_SUB;

	assign stat.bad        = cmd.feed && phase_q == PH_COUNT && !frame_ok;
	assign stat.fin_direct = cmd.feed && ((phase_q == PH_SPEED && sub_q == LAST_SUB)
		|| (phase_q == PH_COUNT && frame_ok && byte_in == 8'd0));
	assign stat.fin_general = cmd.feed && idx_last
		&& ((phase_q == PH_IDS && !is_write_q) || word_we);
	assign stat.last_entry = (CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q;
	assign stat.out_free   = !out_valid_q || res_ready;

	always_comb begin
		entry_kind = KIND_GENERIC;
		if (is_write_q && count_q == CNT_W'(1) && first_id_q == battery_id_q) begin
			entry_kind = KIND_BATTERY;
		end else if (is_write_q && count_q == CNT_W'(ALL_STATE_COUNT) && match_q) begin
			entry_kind = KIND_ALL_STATE;
		end
	end

	mlfp_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_id_ram (
		.clk     (clk),
		.wr_en   (id_we),
		.wr_addr (idx_q),
		.wr_data (byte_in),
		.rd_en   (cmd.rd_issue),
		.rd_addr (emit_idx_q),
		.rd_data (id_rd)
	);

	mlfp_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_word_ram (
		.clk     (clk),
		.wr_en   (word_we),
		.wr_addr (idx_q),
		.wr_data (asm_new),
		.rd_en   (cmd.rd_issue),
		.rd_addr (emit_idx_q),
		.rd_data (word_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			general_hdr_q  <= GENERAL_HDR_RST;
			speed_hdr_q    <= SPEED_HDR_RST;
			read_code_q    <= READ_CODE_RST;
			write_code_q   <= WRITE_CODE_RST;
			battery_id_q   <= BATTERY_ID_RST;
			all_state_id_q <= ALL_STATE_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GENERAL_HDR:  general_hdr_q  <= cfg_data;
				REG_SPEED_HDR:    speed_hdr_q    <= cfg_data;
				REG_READ_CODE:    read_code_q    <= cfg_data;
				REG_WRITE_CODE:   write_code_q   <= cfg_data;
				REG_BATTERY_ID:   battery_id_q   <= cfg_data;
				REG_ALL_STATE_ID: all_state_id_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			sub_q          <= 2'd0;
			idx_q          <= '0;
			emit_idx_q     <= '0;
			dev_q          <= 8'd0;
			rw_q           <= 8'd0;
			first_id_q     <= 8'd0;
			is_write_q     <= 1'b0;
			match_q        <= 1'b1;
			direct_speed_q <= 1'b0;
			count_q        <= '0;
			asm_q          <= 32'd0;
			for (int i = 0; i < LOOKBACK_DEPTH; i++) begin
				queue_q[i] <= 8'd0;
			end
		end else begin
			if (stat.fin_general) begin
				emit_idx_q <= '0;
			end else if (cmd.load_entry) begin
				emit_idx_q <= emit_idx_q + IDX_W'(1);
			end
			if (cmd.feed) begin
				case (phase_q)
					PH_HUNT: begin
						if (byte_in == speed_hdr_q) begin
							phase_q <= PH_SPEED;
							sub_q   <= 2'd0;
							asm_q   <= 32'd0;
						end else if (byte_in == general_hdr_q) begin
							phase_q <= PH_DEVICE;
						end
					end
					PH_SPEED: begin
						asm_q <= asm_new;
						sub_q <= sub_q + 2'd1;
						if (sub_q == LAST_SUB) begin
							phase_q        <= PH_HUNT;
							direct_speed_q <= 1'b1;
						end
					end
					PH_DEVICE: begin
						dev_q   <= byte_in;
						phase_q <= PH_RW;
					end
					PH_RW: begin
						rw_q    <= byte_in;
						phase_q <= PH_COUNT;
					end
					PH_COUNT: begin
						phase_q <= PH_HUNT;
						if (!frame_ok) begin
							queue_q[0] <= dev_q;
							queue_q[1] <= rw_q;
							queue_q[2] <= byte_in;
						end else begin
							is_write_q <= rw_q == write_code_q;
							count_q    <= CNT_W'(byte_in);
							idx_q      <= '0;
							match_q    <= 1'b1;
							if (byte_in == 8'd0) begin
								direct_speed_q <= 1'b0;
							end else begin
								phase_q <= PH_IDS;
							end
						end
					end
					PH_IDS: begin
						if (idx_q == '0) begin
							first_id_q <= byte_in;
						end
						if (byte_in != all_state_id_q) begin
							match_q <= 1'b0;
						end
						idx_q <= idx_q + IDX_W'(1);
						if (idx_last) begin
							if (is_write_q) begin
								phase_q <= PH_WORDS;
								idx_q   <= '0;
								sub_q   <= 2'd0;
								asm_q   <= 32'd0;
							end else begin
								phase_q <= PH_HUNT;
							end
						end
					end
					PH_WORDS: begin
						sub_q <= sub_q + 2'd1;
						if (sub_q == LAST_SUB) begin
							asm_q <= 32'd0;
							idx_q <= idx_q + IDX_W'(1);
							if (idx_last) begin
								phase_q <= PH_HUNT;
							end
						end else begin
							asm_q <= asm_new;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_direct || cmd.load_entry) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			out_index_q <= 4'd0;
			out_id_q    <= 8'd0;
			out_last_q  <= 1'b1;
			if (direct_speed_q) begin
				out_kind_q  <= KIND_SPEED;
				out_dev_q   <= 8'd0;
				out_write_q <= 1'b0;
				out_count_q <= 5'd1;
				out_word_q  <= asm_q;
			end else begin
				out_kind_q  <= KIND_GENERIC;
				out_dev_q   <= dev_q;
				out_write_q <= is_write_q;
				out_count_q <= 5'd0;
				out_word_q  <= 32'd0;
			end
		end else if (cmd.load_entry) begin
			out_kind_q  <= entry_kind;
			out_dev_q   <= dev_q;
			out_write_q <= is_write_q;
			out_count_q <= 5'(count_q);
			out_index_q <= 4'(emit_idx_q);
			out_id_q    <= id_rd;
			out_word_q  <= is_write_q ? word_rd : 32'd0;
			out_last_q  <= stat.last_entry;
		end
	end

	assign res_valid   = out_valid_q;
	assign frame_kind  = out_kind_q;
	assign device_id   = out_dev_q;
	assign is_write    = out_write_q;
	assign entry_count = out_count_q;
	assign entry_index = out_index_q;
	assign entry_id    = out_id_q;
	assign entry_word  = out_word_q;
	assign last_entry  = out_last_q;

endmodule

// File: sv/motor_link_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_link_frame_parser
// Parses received link bytes into speed, battery, all-state and generic
// frame results.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while a frame is being parsed. A bad
// read/write code or an oversized count stalls intake while the device,
// code and count bytes are scanned again for a header. A completed speed
// frame or zero-count frame gives its one result once the output register
// is free; a frame with n entries gives n results, each by an id and word
// store read, then a result register load, and no byte is taken until the
// last is loaded. Results wait in an output register; the stores need no
// clearing after reset. Register writes are taken at any time.
// ----------------------------------------------------------------------------
module motor_link_frame_parser #(
	parameter int MAX_ENTRIES = mlfp_pkg::MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	mlfp_rx_if.sink     rx,
	mlfp_res_if.source  res,
	mlfp_cfg_if.sink    cfg
);
	import mlfp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	mlfp_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	mlfp_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.rx_byte     (rx.rx_byte),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.frame_kind  (res.frame_kind),
		.device_id   (res.device_id),
		.is_write    (res.is_write),
		.entry_count (res.entry_count),
		.entry_index (res.entry_index),
		.entry_id    (res.entry_id),
		.entry_word  (res.entry_word),
		.last_entry  (res.last_entry)
	);

endmodule

// File: sv/mlfp_chk.sv
// ----------------------------------------------------------------------------
// mlfp_chk
// Port-level checks of the frame parser result stream.
// ----------------------------------------------------------------------------
module mlfp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  frame_kind,
	input logic [7:0]  device_id,
	input logic        is_write,
	input logic [4:0]  entry_count,
	input logic [3:0]  entry_index,
	input logic [31:0] entry_word,
	input logic        last_entry
);
	import mlfp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(entry_word)
			&& $stable(entry_index) && $stable(last_entry))
		else $error("stalled result changed");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && entry_count != 5'd0 && entry_count <= 5'd16
			|-> {1'b0, entry_index} < entry_count)
		else $error("entry index beyond entry count");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && entry_count != 5'd0 && entry_count <= 5'd16
			|-> last_entry == ({1'b0, entry_index} + 5'd1 == entry_count))
		else $error("last entry flag wrong");

	a_speed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_kind == KIND_SPEED
			|-> entry_count == 5'd1 && entry_index == 4'd0 && device_id == 8'd0
				&& !is_write && last_entry)
		else $error("malformed speed result");

	a_battery: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_kind == KIND_BATTERY
			|-> entry_count == 5'd1 && is_write && last_entry)
		else $error("malformed battery result");

endmodule

bind motor_link_frame_parser mlfp_chk u_mlfp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.frame_kind  (res.frame_kind),
	.device_id   (res.device_id),
	.is_write    (res.is_write),
	.entry_count (res.entry_count),
	.entry_index (res.entry_index),
	.entry_word  (res.entry_word),
	.last_entry  (res.last_entry)
);
